### hdl/frc_pkg.sv
package frc_pkg;

	typedef enum logic [1:0] {
		KIND_EXEC  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_REG   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_BAD_OP  = 3'd2,
		ST_BAD_FN  = 3'd3,
		ST_STOPPED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_MEM,
		S_OUT
	} state_t;

	// opcodes
	localparam logic [5:0] OP_RTYPE  = 6'h00;
	localparam logic [5:0] OP_LCL    = 6'h01;
	localparam logic [5:0] OP_JUMP   = 6'h02;
	localparam logic [5:0] OP_JAL    = 6'h03;
	localparam logic [5:0] OP_BEQ    = 6'h04;
	localparam logic [5:0] OP_BNE    = 6'h05;
	localparam logic [5:0] OP_LIT    = 6'h06;
	localparam logic [5:0] OP_LCH    = 6'h07;
	localparam logic [5:0] OP_ADDI   = 6'h08;
	localparam logic [5:0] OP_JT     = 6'h09;
	localparam logic [5:0] OP_SLTI   = 6'h0a;
	localparam logic [5:0] OP_ANDI   = 6'h0c;
	localparam logic [5:0] OP_ORI    = 6'h0d;
	localparam logic [5:0] OP_JF     = 6'h10;
	localparam logic [5:0] OP_LOAD   = 6'h23;
	localparam logic [5:0] OP_STORE  = 6'h2b;

	// function codes
	localparam logic [5:0] FN_LSL    = 6'h00;
	localparam logic [5:0] FN_LSR    = 6'h02;
	localparam logic [5:0] FN_ASR    = 6'h03;
	localparam logic [5:0] FN_ASL    = 6'h04;
	localparam logic [5:0] FN_JR     = 6'h08;
	localparam logic [5:0] FN_DIV    = 6'h1a;
	localparam logic [5:0] FN_NAND   = 6'h1b;
	localparam logic [5:0] FN_ADD    = 6'h20;
	localparam logic [5:0] FN_NOT    = 6'h21;
	localparam logic [5:0] FN_SUB    = 6'h22;
	localparam logic [5:0] FN_ANDNA  = 6'h23;
	localparam logic [5:0] FN_AND    = 6'h24;
	localparam logic [5:0] FN_OR     = 6'h25;
	localparam logic [5:0] FN_XOR    = 6'h26;
	localparam logic [5:0] FN_NOR    = 6'h27;
	localparam logic [5:0] FN_XNOR   = 6'h28;
	localparam logic [5:0] FN_ORNB   = 6'h29;
	localparam logic [5:0] FN_SLT    = 6'h2a;
	localparam logic [5:0] FN_PASSA  = 6'h2b;
	localparam logic [5:0] FN_PASSNA = 6'h2c;
	localparam logic [5:0] FN_INCA   = 6'h2d;
	localparam logic [5:0] FN_DECA   = 6'h2e;
	localparam logic [5:0] FN_ADDINC = 6'h2f;
	localparam logic [5:0] FN_SUBDEC = 6'h30;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture the accepted item
		logic exec;      // commit a write, a register read or an execute that needs no divide or memory read
		logic div_start;
		logic div_step;
		logic div_done;  // commit divide result
		logic mem_done;  // commit load / read result
		logic stop;      // set stopped
	} frc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       stopped;
		logic       past_end;
		logic       is_div;
		logic       is_load;
		logic       needs_mem;
		logic       div_last;
		status_t    exec_status;
	} frc_stat_t;

endpackage

### hdl/flag_risc_cpu_step.sv
// Small 32-bit core with six condition flags, 16 registers and a word-wide
// data memory. Each input item executes one instruction, preloads or reads a
// data word, or reads a register, and yields one result item with the next pc,
// a status and the flags. An item passes through the states accept, execute
// and result; a load or a data read adds a memory state for the registered
// read port, and a divide adds a divide state, in which a restoring divider
// yields one quotient bit a cycle, and then the memory state. One item is in
// flight at a time; a new item is taken once the result has been taken. A halt,
// bad opcode, bad function or a pc at or past program_length stops the core;
// later executes return status 4 with no effect.
module flag_risc_cpu_step #(
	parameter int DATA_DEPTH    = 1024,
	parameter int PROGRAM_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind[1:0], instruction[33:2], access_address[43:34], write_value[75:44]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc[9:0], status[12:10], flag_bits[18:13], read_value[50:19]
	output logic [55:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	import frc_pkg::*;

	frc_cmd_t  cmd;
	frc_stat_t st;
	logic      in_fire;
	logic [9:0]  next_pc;
	logic [2:0]  status;
	logic [5:0]  flag_bits;
	logic [31:0] read_value;

	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	frc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.kind(kind_t'(s_tdata[1:0])), .out_take(m_tready), .st(st), .cmd(cmd),
		.in_ready(s_tready), .out_valid(m_tvalid)
	);

	frc_dpath #(.DATA_DEPTH(DATA_DEPTH), .PROGRAM_DEPTH(PROGRAM_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .kind(kind_t'(s_tdata[1:0])),
		.instruction(s_tdata[33:2]), .access_address(s_tdata[43:34]),
		.write_value(s_tdata[75:44]), .cfg_we(cfg_valid), .cfg_data(cfg_data),
		.st(st), .next_pc(next_pc), .status(status), .flag_bits(flag_bits),
		.read_value(read_value)
	);

	assign m_tdata = {5'd0, read_value, flag_bits, status, next_pc};
endmodule

### hdl/frc_ram.sv
module frc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/frc_ctrl.sv
module frc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  frc_pkg::kind_t    kind,
	input  logic              out_take,
	input  frc_pkg::frc_stat_t st,
	output frc_pkg::frc_cmd_t cmd,
	output logic              in_ready,
	output logic              out_valid
);
	import frc_pkg::*;

	state_t state_q, state_n;
	kind_t  kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_EXEC;
		end else begin
			state_q <= state_n;
			if (in_fire) kind_q <= kind;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.latch = 1'b1;
					state_n   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (kind_q != KIND_EXEC) begin
					// reads wait in S_MEM for registered memory data
					if (st.needs_mem) state_n = S_MEM;
					else begin
						cmd.exec = 1'b1;
						state_n  = S_OUT;
					end
				end else if (st.stopped) begin
					cmd.exec = 1'b1;
					state_n  = S_OUT;
				end else if (st.past_end || st.exec_status != ST_OK) begin
					cmd.stop = 1'b1;
					cmd.exec = 1'b1;
					state_n  = S_OUT;
				end else if (st.is_div) begin
					cmd.div_start = 1'b1;
					state_n       = S_DIV;
				end else if (st.is_load) begin
					state_n = S_MEM;
				end else begin
					cmd.exec = 1'b1;
					state_n  = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_n = S_MEM;
			end
			S_MEM: begin
				if (kind_q == KIND_EXEC && st.is_div) cmd.div_done = 1'b1;
				else cmd.mem_done = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_take) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule

### hdl/frc_dpath.sv
module frc_dpath #(
	parameter int DATA_DEPTH    = 1024,
	parameter int PROGRAM_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  frc_pkg::frc_cmd_t  cmd,
	input  frc_pkg::kind_t     kind,
	input  logic [31:0]        instruction,
	input  logic [9:0]         access_address,
	input  logic [31:0]        write_value,
	input  logic               cfg_we,
	input  logic [10:0]        cfg_data,
	output frc_pkg::frc_stat_t st,
	output logic [9:0]         next_pc,
	output logic [2:0]         status,
	output logic [5:0]         flag_bits,
	output logic [31:0]        read_value
);
	import frc_pkg::*;

	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int PAW = $clog2(PROGRAM_DEPTH);

	logic [31:0] regs_q [16];
	logic [5:0]  flags_q;
	logic [PAW-1:0] pc_q;
	logic        stopped_q;
	logic [10:0] plen_q;
	kind_t       kind_q;
	logic [31:0] ins_q;
	logic [9:0]  addr_q;
	logic [31:0] wv_q;
	logic [2:0]  status_q;
	logic [31:0] rv_q;

	// divider
	logic [31:0] dq_q, drem_q, ddiv_q;
	logic        dneg_q;
	logic [5:0]  dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= 11'd1024;
		else if (cfg_we) plen_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			ins_q  <= instruction;
			addr_q <= access_address;
			wv_q   <= write_value;
		end
	end

	// decode
	logic [5:0]  op, fn;
	logic [4:0]  rsf;
	logic [3:0]  rs, rt, rd;
	logic [15:0] lo;
	logic [31:0] imm, a, b, rtv;
	assign op  = ins_q[31:26];
	assign rsf = ins_q[25:21];
	assign rs  = ins_q[24:21];
	assign rt  = ins_q[19:16];
	assign rd  = ins_q[14:11];
	assign fn  = ins_q[5:0];
	assign lo  = ins_q[15:0];
	assign imm = {{16{lo[15]}}, lo};
	assign a   = regs_q[rs];
	assign b   = regs_q[rt];
	assign rtv = b;

	logic [10:0] len;
	assign len = (32'(plen_q) > 32'(PROGRAM_DEPTH)) ? 11'(PROGRAM_DEPTH) : plen_q;

	// memory
	logic           mem_we;
	logic [DAW-1:0] mem_waddr, mem_raddr;
	logic [31:0]    mem_wdata, mem_rdata;

	frc_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_ram (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign mem_raddr = (kind_q == KIND_EXEC) ? a[DAW-1:0] : DAW'(addr_q);

	function automatic logic [5:0] rflags(input logic [31:0] r, input logic ov, input logic cy);
		rflags = {cy, (r == 32'd0) | r[31], ov, r[31], r != 32'd0, r == 32'd0};
	endfunction

	// execute
	logic [31:0]    r;
	logic           ov, cy, wr_rd, wr_rt, wr_flags, wr_r15, set_pc;
	logic [PAW-1:0] npc, branch, seq;
	logic [2:0]     est;
	logic [32:0]    s1, s2;
	logic [31:0]    t;
	logic           fl;

	assign seq    = pc_q + PAW'(1);
	assign branch = PAW'(32'(pc_q) + 32'd1 + imm);
	assign fl     = (rsf < 5'd6) && flags_q[rsf[2:0]];

	always_comb begin
		r = '0; ov = 1'b0; cy = 1'b0; t = '0; s1 = '0; s2 = '0;
		wr_rd = 1'b0; wr_rt = 1'b0; wr_flags = 1'b0; wr_r15 = 1'b0;
		npc = seq; est = ST_OK;
		case (op)
			OP_RTYPE: begin
				wr_rd = 1'b1; wr_flags = 1'b1;
				case (fn)
					FN_ADD: begin
						s1 = {1'b0, a} + {1'b0, b}; r = s1[31:0]; cy = s1[32];
						ov = (a[31] == b[31]) && (a[31] != r[31]);
					end
					FN_SUB: begin
						r = a - b; s1 = {1'b0, a} + {1'b0, b}; cy = s1[32];
						ov = (a[31] == ~b[31]) && (a[31] != r[31]);
					end
					FN_AND:    r = a & b;
					FN_OR:     r = a | b;
					FN_NOT:    r = ~a;
					FN_XOR:    r = a ^ b;
					FN_ANDNA:  r = ~a & b;
					FN_NOR:    r = ~(a | b);
					FN_XNOR:   r = ~(a ^ b);
					FN_ORNB:   r = a | ~b;
					FN_NAND:   r = ~(a & b);
					FN_PASSA:  r = a;
					FN_PASSNA: r = ~a;
					FN_INCA: begin
						s1 = {1'b0, a} + 33'd1; r = s1[31:0]; cy = s1[32];
						ov = !a[31] && r[31];
					end
					FN_DECA: begin
						r = a - 32'd1; cy = a != 32'd0;
						ov = a[31] && !r[31];
					end
					FN_ADDINC: begin
						t = a + b; s2 = {1'b0, t} + 33'd1; r = s2[31:0]; cy = s2[32];
						ov = !t[31] && r[31];
					end
					FN_SUBDEC: begin
						t = a - b; r = t - 32'd1; cy = t != 32'd0;
						ov = t[31] && !r[31];
					end
					FN_LSL: begin r = {a[30:0], 1'b0}; cy = a[31]; end
					FN_LSR: r = {1'b0, a[31:1]};
					FN_ASL: begin
						r = {a[30:0], 1'b0}; cy = a[31]; ov = a[31] ^ a[30];
					end
					FN_ASR: r = {a[31], a[31:1]};
					FN_SLT: r = {31'd0, $signed(a) < $signed(b)};
					FN_DIV: begin wr_rd = 1'b0; wr_flags = 1'b0; end
					FN_JR: begin wr_rd = 1'b0; wr_flags = 1'b0; npc = a[PAW-1:0]; end
					default: begin wr_rd = 1'b0; wr_flags = 1'b0; est = ST_BAD_FN; end
				endcase
			end
			OP_JUMP: begin
				if (32'(ins_q[25:0]) == 32'(pc_q)) est = ST_HALT;
				else npc = ins_q[PAW-1:0];
			end
			OP_LCH:   begin wr_rt = 1'b1; r = {lo, rtv[15:0]}; end
			OP_LCL:   begin wr_rt = 1'b1; r = {rtv[31:16], lo}; end
			OP_LIT:   begin wr_rt = 1'b1; r = imm; end
			OP_JAL:   begin wr_r15 = 1'b1; npc = a[PAW-1:0]; end
			OP_BEQ:   if (rtv == a) npc = branch;
			OP_BNE:   if (rtv != a) npc = branch;
			OP_JT:    if (fl) npc = branch;
			OP_JF:    if (!fl) npc = branch;
			OP_LOAD, OP_STORE: ;
			OP_ADDI: begin
				wr_rt = 1'b1; wr_flags = 1'b1;
				s1 = {1'b0, a} + {1'b0, imm}; r = s1[31:0]; cy = s1[32];
				ov = (a[31] == imm[31]) && (a[31] != r[31]);
			end
			OP_SLTI: begin
				wr_rt = 1'b1; wr_flags = 1'b1; r = {31'd0, $signed(a) < $signed(imm)};
			end
			OP_ANDI: begin wr_rt = 1'b1; wr_flags = 1'b1; r = a & imm; end
			OP_ORI:  begin wr_rt = 1'b1; wr_flags = 1'b1; r = a | imm; end
			default: est = ST_BAD_OP;
		endcase
	end

	assign st.stopped     = stopped_q;
	assign st.past_end    = 32'(pc_q) >= 32'(len);
	assign st.is_div      = op == OP_RTYPE && fn == FN_DIV;
	assign st.is_load     = op == OP_LOAD;
	assign st.needs_mem   = kind_q == KIND_READ;
	assign st.div_last    = dcnt_q == 6'd31;
	assign st.exec_status = status_t'(est);

	assign mem_we    = (cmd.exec && kind_q == KIND_WRITE) ||
		(cmd.exec && kind_q == KIND_EXEC && !stopped_q && !cmd.stop && op == OP_STORE);
	assign mem_waddr = (kind_q == KIND_EXEC) ? a[DAW-1:0] : DAW'(addr_q);
	assign mem_wdata = (kind_q == KIND_EXEC) ? rtv : wv_q;

	// restoring divider on magnitudes, one quotient bit a cycle
	logic [31:0] ma, mb, dq_fin;
	logic [32:0] trial;
	assign ma    = a[31] ? -a : a;
	assign mb    = b[31] ? -b : b;
	assign trial = {drem_q, dq_q[31]} - {1'b0, ddiv_q};
	assign dq_fin = (b == 32'd0) ? 32'd0 : (dneg_q ? -dq_q : dq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= '0;
		else if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q <= ma; drem_q <= '0; ddiv_q <= mb; dneg_q <= a[31] ^ b[31];
		end else if (cmd.div_step) begin
			if (!trial[32]) begin
				drem_q <= trial[31:0]; dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				drem_q <= {drem_q[30:0], dq_q[31]}; dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end

	logic live;
	assign live = kind_q == KIND_EXEC && !stopped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			flags_q   <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			status_q  <= ST_OK;
			rv_q      <= '0;
		end else begin
			if (cmd.exec) begin
				rv_q <= (kind_q == KIND_REG) ? regs_q[addr_q[3:0]] : 32'd0;
				if (kind_q != KIND_EXEC) status_q <= stopped_q ? ST_STOPPED : ST_OK;
				else if (stopped_q || st.past_end) status_q <= ST_STOPPED;
				else status_q <= est;
				if (cmd.stop) stopped_q <= 1'b1;
				else if (live) begin
					if (wr_rd) regs_q[rd] <= r;
					if (wr_rt) regs_q[rt] <= r;
					if (wr_r15) regs_q[15] <= 32'(seq) == 32'd0 ? 32'(pc_q) + 32'd1 : 32'(seq);
					if (wr_flags) flags_q <= rflags(r, ov, cy);
					pc_q <= npc;
				end
			end
			if (cmd.div_done) begin
				regs_q[rd] <= dq_fin;
				flags_q    <= rflags(dq_fin, 1'b0, 1'b0);
				pc_q       <= seq;
				status_q   <= ST_OK;
				rv_q       <= '0;
			end
			if (cmd.mem_done) begin
				if (kind_q == KIND_EXEC) begin
					regs_q[rt] <= mem_rdata;
					flags_q[0] <= mem_rdata == 32'd0;
					pc_q       <= seq;
					status_q   <= ST_OK;
					rv_q       <= '0;
				end else begin
					rv_q     <= mem_rdata;
					status_q <= stopped_q ? ST_STOPPED : ST_OK;
				end
			end
		end
	end

	assign next_pc    = 10'(pc_q);
	assign status     = status_q;
	assign flag_bits  = flags_q;
	assign read_value = rv_q;
endmodule

### tb/flag_risc_cpu_step_test.sv
`timescale 1ns / 1ps

module flag_risc_cpu_step_test;
	import frc_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [31:0] ins;
		logic [9:0]  addr;
		logic [31:0] wv;
	} core_item_t;

	typedef struct {
		logic [9:0]  npc;
		status_t     st;
		logic [5:0]  flags;
		logic [31:0] rv;
	} core_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	flag_risc_cpu_step DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// core state as predicted
	logic [31:0] regs [16];
	logic [5:0]  cflags;
	logic [9:0]  core_pc;
	bit          core_stopped;
	int          prog_len;
	logic [31:0] dmem [1024];
	bit          written [1024];
	int          written_list [$];

	logic [79:0]  pending_items [$];
	core_result_t expected_results [$];
	int           errors = 0;

	logic [5:0] i_ops [14] = '{OP_LCL, OP_JAL, OP_BEQ, OP_BNE, OP_LIT, OP_LCH, OP_ADDI,
		OP_JT, OP_SLTI, OP_ANDI, OP_ORI, OP_JF, OP_LOAD, OP_STORE};
	logic [5:0] r_fns [24] = '{FN_LSL, FN_LSR, FN_ASR, FN_ASL, FN_JR, FN_DIV, FN_NAND,
		FN_ADD, FN_NOT, FN_SUB, FN_ANDNA, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_XNOR,
		FN_ORNB, FN_SLT, FN_PASSA, FN_PASSNA, FN_INCA, FN_DECA, FN_ADDINC, FN_SUBDEC};

	function automatic logic [5:0] mk_flags(logic [31:0] r, bit ov, bit cy);
		return {cy, (r == 0) || r[31], ov, r[31], r != 0, r == 0};
	endfunction

	function automatic bit add_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
		return a[31] == b[31] && a[31] != r[31];
	endfunction

	function automatic bit sub_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
		return a[31] == !b[31] && a[31] != r[31];
	endfunction

	function automatic bit carry_out(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32];
	endfunction

	function automatic int eff_len();
		return prog_len > 1024 ? 1024 : prog_len;
	endfunction

	// one item through the core; state is only updated when commit is set
	function automatic core_result_t step_core(input core_item_t it, input bit commit,
			output bit unready);
		logic [31:0] rf [16];
		logic [5:0]  f, op, fn;
		logic [9:0]  p, np, maddr, br;
		bit          s, ov, cy, wr_rd, mem_w, fl;
		status_t     st;
		logic [31:0] rv, a, b, r, t, imm, mdata;
		logic [4:0]  rsf;
		logic [3:0]  rs, rt, rd;
		logic [15:0] lo;
		core_result_t res;
		rf = regs;
		f = cflags;
		p = core_pc;
		s = core_stopped;
		st = ST_OK;
		rv = '0;
		mem_w = 0;
		maddr = '0;
		mdata = '0;
		unready = 0;
		op = it.ins[31:26];
		fn = it.ins[5:0];
		rsf = it.ins[25:21];
		rs = rsf[3:0];
		rt = it.ins[19:16];
		rd = it.ins[14:11];
		lo = it.ins[15:0];
		imm = {{16{lo[15]}}, lo};
		a = rf[rs];
		b = rf[rt];
		t = {22'd0, p} + 32'd1 + imm;
		br = t[9:0];
		fl = rsf < 6 && f[rsf];
		case (it.kind)
			KIND_WRITE: begin
				mem_w = 1;
				maddr = it.addr;
				mdata = it.wv;
			end
			KIND_READ: begin
				rv = dmem[it.addr];
				unready = !written[it.addr];
			end
			KIND_REG: rv = rf[it.addr[3:0]];
			default: begin
				if (s) begin
					st = ST_STOPPED;
				end else if (p >= eff_len()) begin
					s = 1;
					st = ST_STOPPED;
				end else begin
					np = p + 10'd1;
					ov = 0;
					cy = 0;
					if (op == OP_RTYPE) begin
						wr_rd = 1;
						case (fn)
							FN_ADD: begin
								r = a + b; ov = add_ovf(a, b, r); cy = carry_out(a, b);
							end
							FN_SUB: begin
								r = a - b; ov = sub_ovf(a, b, r); cy = carry_out(a, b);
							end
							FN_AND:    r = a & b;
							FN_OR:     r = a | b;
							FN_NOT:    r = ~a;
							FN_XOR:    r = a ^ b;
							FN_ANDNA:  r = ~a & b;
							FN_NOR:    r = ~(a | b);
							FN_XNOR:   r = ~(a ^ b);
							FN_ORNB:   r = a | ~b;
							FN_NAND:   r = ~(a & b);
							FN_PASSA:  r = a;
							FN_PASSNA: r = ~a;
							FN_INCA: begin
								r = a + 1; ov = add_ovf(a, 1, r); cy = carry_out(a, 1);
							end
							FN_DECA: begin
								r = a - 1; ov = sub_ovf(a, 1, r); cy = carry_out(a, '1);
							end
							FN_ADDINC: begin
								t = a + b; r = t + 1; ov = add_ovf(t, 1, r); cy = carry_out(t, 1);
							end
							FN_SUBDEC: begin
								t = a - b; r = t - 1; ov = sub_ovf(t, 1, r); cy = carry_out(t, '1);
							end
							FN_LSL: begin
								r = a << 1; cy = a[31];
							end
							FN_LSR: r = a >> 1;
							FN_ASL: begin
								r = a << 1; cy = a[31]; ov = a[31] ^ a[30];
							end
							FN_ASR: r = {a[31], a[31:1]};
							FN_SLT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
							FN_DIV: begin
								if (b == 0)
									r = '0;
								else if (a == 32'h8000_0000 && b == '1)
									r = a;
								else
									r = $signed(a) / $signed(b);
							end
							FN_JR: begin
								np = a[9:0]; wr_rd = 0;
							end
							default: begin
								st = ST_BAD_FN; wr_rd = 0;
							end
						endcase
						if (wr_rd) begin
							rf[rd] = r;
							f = mk_flags(r, ov, cy);
						end
					end else if (op == OP_JUMP) begin
						if (it.ins[25:0] == {16'd0, p})
							st = ST_HALT;
						else
							np = it.ins[9:0];
					end else begin
						case (op)
							OP_LCH: rf[rt] = {lo, rf[rt][15:0]};
							OP_JAL: begin
								rf[15] = {22'd0, p} + 32'd1; np = a[9:0];
							end
							OP_BEQ: if (rf[rt] == a) np = br;
							OP_BNE: if (rf[rt] != a) np = br;
							OP_LIT: rf[rt] = imm;
							OP_LCL: rf[rt] = {rf[rt][31:16], lo};
							OP_JT:  if (fl) np = br;
							OP_JF:  if (!fl) np = br;
							OP_LOAD: begin
								unready = !written[a[9:0]];
								r = dmem[a[9:0]];
								rf[rt] = r;
								f[0] = (r == 0);
							end
							OP_STORE: begin
								mem_w = 1; maddr = a[9:0]; mdata = rf[rt];
							end
							OP_ADDI: begin
								r = a + imm; rf[rt] = r;
								f = mk_flags(r, add_ovf(a, imm, r), carry_out(a, imm));
							end
							OP_SLTI: begin
								r = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
								rf[rt] = r; f = mk_flags(r, 0, 0);
							end
							OP_ANDI: begin
								r = a & imm; rf[rt] = r; f = mk_flags(r, 0, 0);
							end
							OP_ORI: begin
								r = a | imm; rf[rt] = r; f = mk_flags(r, 0, 0);
							end
							default: st = ST_BAD_OP;
						endcase
					end
					if (st != ST_OK)
						s = 1;
					else
						p = np;
				end
				if (s && it.kind != KIND_EXEC)
					st = ST_STOPPED;
			end
		endcase
		if (it.kind != KIND_EXEC)
			st = s ? ST_STOPPED : ST_OK;
		if (commit) begin
			if (st == ST_OK || it.kind != KIND_EXEC) begin
				regs = rf;
				cflags = f;
				core_pc = p;
				if (mem_w) begin
					dmem[maddr] = mdata;
					if (!written[maddr])
						written_list.push_back(maddr);
					written[maddr] = 1;
				end
			end
			core_stopped = s;
		end
		res.npc = (commit || st == ST_OK || it.kind != KIND_EXEC) ? p : core_pc;
		res.st = st;
		res.flags = (st == ST_OK || it.kind != KIND_EXEC) ? f : cflags;
		res.rv = rv;
		return res;
	endfunction

	function automatic void emit(core_item_t it);
		bit unused;
		expected_results.push_back(step_core(it, 1, unused));
		pending_items.push_back({4'd0, it.wv, it.addr, it.ins, it.kind});
	endfunction

	function automatic core_item_t mk_item(kind_t k, logic [31:0] ins, logic [9:0] addr,
			logic [31:0] wv);
		core_item_t it;
		it.kind = k;
		it.ins = ins;
		it.addr = addr;
		it.wv = wv;
		return it;
	endfunction

	function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd);
		return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic void emit_exec(logic [31:0] ins);
		emit(mk_item(KIND_EXEC, ins, 10'($urandom), $urandom));
	endfunction

	function automatic void emit_write(logic [9:0] addr);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = '0;
			3: v = '1;
			default: v = $urandom;
		endcase
		emit(mk_item(KIND_WRITE, $urandom, addr, v));
	endfunction

	function automatic void emit_jump_to(int lo_t, int hi_t);
		int tgt;
		do tgt = $urandom_range(lo_t, hi_t); while (tgt == core_pc);
		emit_exec({OP_JUMP, 6'($urandom) & 6'h0f, 10'd0, 10'(tgt)});
	endfunction

	function automatic logic [31:0] rand_ins();
		logic [15:0] imm;
		int sel;
		sel = $urandom_range(0, 99);
		case ($urandom_range(0, 4))
			0: imm = 16'h0000;
			1: imm = 16'h7fff;
			2: imm = 16'h8000;
			3: imm = 16'hffff;
			default: imm = 16'($urandom);
		endcase
		if (sel < 45)
			return {OP_RTYPE, 20'($urandom), r_fns[$urandom_range(0, 23)]};
		else if (sel < 50)
			return {OP_JUMP, 26'($urandom)};
		else
			return {i_ops[$urandom_range(0, 13)], 10'($urandom), imm};
	endfunction

	// a well-formed execute that neither stops the core nor leaves the program
	function automatic void emit_good_exec();
		core_item_t it;
		core_result_t res;
		bit unready;
		int tries;
		tries = 0;
		forever begin
			it = mk_item(KIND_EXEC, rand_ins(), 10'($urandom), $urandom);
			res = step_core(it, 0, unready);
			if (unready) begin
				emit_write(regs[it.ins[24:21]][9:0]);
				res = step_core(it, 0, unready);
			end
			if (res.st == ST_OK && res.npc < eff_len()) begin
				emit(it);
				return;
			end
			tries++;
			if (tries > 40) begin
				emit_jump_to(0, eff_len() - 1);
				return;
			end
		end
	endfunction

	function automatic void emit_random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 72) begin
			emit_good_exec();
		end else if (sel < 82) begin
			emit_write($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
				: 10'($urandom));
		end else if (sel < 91) begin
			if (written_list.size() == 0)
				emit_write(10'($urandom));
			emit(mk_item(KIND_READ, $urandom,
				10'(written_list[$urandom_range(0, written_list.size() - 1)]), $urandom));
		end else begin
			emit(mk_item(KIND_REG, $urandom, 10'($urandom), $urandom));
		end
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_length(int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 11'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		prog_len = v;
	endtask

	// driver: bursts of items with random gaps
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				s_tdata <= pending_items.pop_front();
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side stall pattern
	logic [9:0] stall_phase = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 10'd1;
			case (stall_phase[9:8])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= stall_phase[2:0] != 3'd0;
				default: m_tready <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		core_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result item, actual %h", $time, m_tdata);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (m_tdata[9:0] !== e.npc || m_tdata[12:10] !== e.st ||
						m_tdata[18:13] !== e.flags || m_tdata[50:19] !== e.rv) begin
					$display("%0t: mismatch expected pc %0d st %0d fl %b rv %h", $time,
						e.npc, e.st, e.flags, e.rv);
					$display("%0t:          actual pc %0d st %0d fl %b rv %h", $time,
						m_tdata[9:0], m_tdata[12:10], m_tdata[18:13], m_tdata[50:19]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int lens [5];
		int pick;
		for (int i = 0; i < 16; i++) regs[i] = '0;
		for (int i = 0; i < 1024; i++) begin
			dmem[i] = '0;
			written[i] = 0;
		end
		cflags = '0;
		core_pc = '0;
		core_stopped = 0;
		prog_len = 1024;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and corner cases
		emit(mk_item(KIND_WRITE, '0, 10'd0, 32'h8000_0000));
		emit(mk_item(KIND_WRITE, '1, 10'd1023, 32'h7fff_ffff));
		emit(mk_item(KIND_READ, '0, 10'd1023, '1));
		emit(mk_item(KIND_REG, '1, 10'd1023, '0));
		emit_exec(itype(OP_LCH, 5'd0, 5'd17, 16'h8000));      // rt with high bit set
		emit_exec(itype(OP_LIT, 5'd0, 5'd2, 16'hffff));
		emit_exec(rtype(FN_DIV, 5'd1, 5'd2, 5'd3));            // most negative by -1
		emit_exec(rtype(FN_DIV, 5'd1, 5'd0, 5'd4));            // divide by zero
		emit_exec(rtype(FN_ADD, 5'd1, 5'd1, 5'd5));
		emit_exec(rtype(FN_ASL, 5'd1, 5'd0, 5'd6));
		emit_exec(rtype(FN_LSR, 5'd2, 5'd0, 5'd7));
		emit_exec(rtype(FN_ASR, 5'd2, 5'd0, 5'd8));
		emit_exec(rtype(FN_SUB, 5'd0, 5'd2, 5'd9));
		emit_exec(rtype(FN_SUBDEC, 5'd0, 5'd2, 5'd10));
		emit_exec(rtype(FN_DECA, 5'd0, 5'd0, 5'd11));
		emit_exec(itype(OP_SLTI, 5'd2, 5'd12, 16'h0001));
		emit_exec(itype(OP_LCL, 5'd0, 5'd2, 16'h1234));
		emit_exec(rtype(FN_NOT, 5'd0, 5'd0, 5'd29));
		emit_exec(itype(OP_JT, 5'd31, 5'd0, 16'h0005));        // flag index out of range
		emit_exec(itype(OP_JF, 5'd7, 5'd0, 16'h0002));
		emit_exec(itype(OP_STORE, 5'd0, 5'd2, 16'h0000));
		emit_exec(itype(OP_LOAD, 5'd0, 5'd14, 16'h0000));
		emit_exec({OP_JUMP, 16'h0001, core_pc});                // jump to own pc, no halt
		emit_exec(itype(OP_JAL, 5'd16, 5'd0, 16'h0000));
		wait_drained();

		lens = '{1024, 2047, 16, $urandom_range(5, 1023), 1000};
		for (int ph = 0; ph < 5; ph++) begin
			emit_jump_to(0, 3);
			wait_drained();
			write_length(lens[ph]);
			repeat (380) emit_random_item();
			wait_drained();
		end

		// stop the core one way, then check that it stays stopped
		pick = $urandom_range(0, 3);
		if (pick == 0) begin
			write_length(0);
			emit_exec(rand_ins());
		end else if (pick == 1) begin
			emit_exec({OP_JUMP, 16'd0, core_pc});
		end else if (pick == 2) begin
			emit_exec({6'h3f, 26'($urandom)});
		end else begin
			emit_exec({OP_RTYPE, 20'($urandom), 6'h3f});
		end
		repeat (6) begin
			emit_exec(rand_ins());
			emit(mk_item(KIND_REG, $urandom, 10'($urandom), $urandom));
		end
		emit_write(10'd7);
		emit(mk_item(KIND_READ, $urandom, 10'd7, $urandom));
		wait_drained();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
